### rtl/tgc_pkg.sv
// Package with the shared types, codes and helpers of the touch gesture classifier.
`timescale 1ns / 1ps
package tgc_pkg;

  // Coordinate width of the touch panel.
  localparam int COORD_BITS = 12;
  // Peak travel holds the full Manhattan distance with headroom.
  localparam int TRAVEL_BITS = COORD_BITS + 2;

  // Gesture codes.
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_TAP   = 3'd1;
  localparam logic [2:0] KIND_LONG  = 3'd2;
  localparam logic [2:0] KIND_LEFT  = 3'd3;
  localparam logic [2:0] KIND_RIGHT = 3'd4;
  localparam logic [2:0] KIND_UP    = 3'd5;
  localparam logic [2:0] KIND_DOWN  = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [2:0] REG_LONG_TIME  = 3'd1;
  localparam logic [2:0] REG_LONG_SLOP  = 3'd2;
  localparam logic [2:0] REG_SWIPE_TOUT = 3'd3;
  localparam logic [2:0] REG_SWIPE_THR  = 3'd4;

  // Input sample.
  typedef struct packed {
    logic                  touching;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [31:0]           time_ms;
  } tgc_in_t;

  // Result item.
  typedef struct packed {
    logic [2:0]            kind;
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
  } tgc_out_t;

  // Configuration register set.
  typedef struct packed {
    logic [15:0] debounce_window;
    logic [15:0] long_press_time;
    logic [12:0] long_press_slop;
    logic [15:0] swipe_timeout;
    logic [12:0] swipe_threshold;
  } tgc_cfg_t;

  // Touch tracking status seen by the top level.
  typedef struct packed {
    logic is_down;
    logic has_fired;
  } tgc_status_t;

  // Absolute difference of two coordinates.
  function automatic logic [COORD_BITS-1:0] absdiff(input logic [COORD_BITS-1:0] a,
                                                    input logic [COORD_BITS-1:0] b);
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/tgc_core.sv
// Touch tracking state and single-pass gesture classification.
`timescale 1ns / 1ps
module tgc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 sample_fire,
  input  tgc_pkg::tgc_in_t     sample,
  input  tgc_pkg::tgc_cfg_t    cfg,
  output tgc_pkg::tgc_out_t    result,
  output tgc_pkg::tgc_status_t status
);
  import tgc_pkg::*;

  logic                   is_down_r, is_down_nxt;
  logic                   has_fired_r, has_fired_nxt;
  logic [TRAVEL_BITS-1:0] peak_travel_r, peak_travel_nxt;
  logic [COORD_BITS-1:0]  start_px_r, start_px_nxt;
  logic [COORD_BITS-1:0]  start_py_r, start_py_nxt;
  logic [COORD_BITS-1:0]  recent_px_r, recent_px_nxt;
  logic [COORD_BITS-1:0]  recent_py_r, recent_py_nxt;
  logic [31:0]            press_time_r, press_time_nxt;
  logic [31:0]            lift_time_r, lift_time_nxt;

  logic [31:0]            since_lift;
  logic [31:0]            held;
  logic                   bounced;
  logic [TRAVEL_BITS-1:0] travel;
  logic [TRAVEL_BITS-1:0] peak_upd;
  logic [COORD_BITS-1:0]  adx;
  logic [COORD_BITS-1:0]  ady;
  logic                   far_move;
  logic                   abandoned;

  // Shared time and distance terms.
  assign since_lift = sample.time_ms - lift_time_r;
  assign held       = sample.time_ms - press_time_r;
  assign bounced    = (lift_time_r != 32'd0) && (since_lift < {16'd0, cfg.debounce_window});
  assign travel     = TRAVEL_BITS'(absdiff(sample.pos_x, start_px_r))
                    + TRAVEL_BITS'(absdiff(sample.pos_y, start_py_r));
  assign peak_upd   = (travel > peak_travel_r) ? travel : peak_travel_r;
  assign adx        = absdiff(recent_px_r, start_px_r);
  assign ady        = absdiff(recent_py_r, start_py_r);
  assign far_move   = ({1'b0, adx} > 13'(cfg.swipe_threshold))
                   || ({1'b0, ady} > 13'(cfg.swipe_threshold));
  assign abandoned  = (held > {16'd0, cfg.swipe_timeout}) && far_move;

  // Next state and result for one sample.
  always_comb begin
    is_down_nxt     = is_down_r;
    has_fired_nxt   = has_fired_r;
    peak_travel_nxt = peak_travel_r;
    start_px_nxt    = start_px_r;
    start_py_nxt    = start_py_r;
    recent_px_nxt   = recent_px_r;
    recent_py_nxt   = recent_py_r;
    press_time_nxt  = press_time_r;
    lift_time_nxt   = lift_time_r;
    result          = '0;
    if (sample.touching && !is_down_r) begin
      // A new touch starts unless it lands inside the debounce window.
      if (!bounced) begin
        is_down_nxt     = 1'b1;
        has_fired_nxt   = 1'b0;
        peak_travel_nxt = '0;
        start_px_nxt    = sample.pos_x;
        start_py_nxt    = sample.pos_y;
        recent_px_nxt   = sample.pos_x;
        recent_py_nxt   = sample.pos_y;
        press_time_nxt  = sample.time_ms;
      end
    end else if (sample.touching && is_down_r) begin
      // Finger held: track travel and fire a long press once.
      recent_px_nxt   = sample.pos_x;
      recent_py_nxt   = sample.pos_y;
      peak_travel_nxt = peak_upd;
      if (!has_fired_r && (peak_upd <= TRAVEL_BITS'(cfg.long_press_slop))
          && (held >= {16'd0, cfg.long_press_time})) begin
        has_fired_nxt   = 1'b1;
        result.kind     = KIND_LONG;
        result.origin_x = start_px_r;
        result.origin_y = start_py_r;
      end
    end else if (!sample.touching && is_down_r) begin
      // Release: tap or swipe along the dominant axis, none if abandoned.
      is_down_nxt   = 1'b0;
      lift_time_nxt = sample.time_ms;
      if (!has_fired_r) begin
        result.origin_x = start_px_r;
        result.origin_y = start_py_r;
        if (abandoned) begin
          result.kind = KIND_NONE;
        end else if (adx > ady) begin
          if ({1'b0, adx} >= 13'(cfg.swipe_threshold)) begin
            result.kind = (recent_px_r < start_px_r) ? KIND_LEFT : KIND_RIGHT;
          end else begin
            result.kind = KIND_TAP;
          end
        end else begin
          if ({1'b0, ady} >= 13'(cfg.swipe_threshold)) begin
            result.kind = (recent_py_r < start_py_r) ? KIND_UP : KIND_DOWN;
          end else begin
            result.kind = KIND_TAP;
          end
        end
      end
    end
  end

  // State registers, updated on each accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      is_down_r     <= 1'b0;
      has_fired_r   <= 1'b0;
      peak_travel_r <= '0;
      start_px_r    <= '0;
      start_py_r    <= '0;
      recent_px_r   <= '0;
      recent_py_r   <= '0;
      press_time_r  <= '0;
      lift_time_r   <= '0;
    end else if (sample_fire) begin
      is_down_r     <= is_down_nxt;
      has_fired_r   <= has_fired_nxt;
      peak_travel_r <= peak_travel_nxt;
      start_px_r    <= start_px_nxt;
      start_py_r    <= start_py_nxt;
      recent_px_r   <= recent_px_nxt;
      recent_py_r   <= recent_py_nxt;
      press_time_r  <= press_time_nxt;
      lift_time_r   <= lift_time_nxt;
    end
  end

  assign status.is_down   = is_down_r;
  assign status.has_fired = has_fired_r;

endmodule

### rtl/tgc_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
module tgc_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tgc_pkg::tgc_out_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output tgc_pkg::tgc_out_t out_data
);
  import tgc_pkg::*;

  logic     out_valid_r, out_valid_nxt;
  logic     skid_valid_r, skid_valid_nxt;
  tgc_out_t out_data_r, out_data_nxt;
  tgc_out_t skid_data_r, skid_data_nxt;
  logic     head_free;

  assign head_free = !out_valid_r || !out_stall;

  // Refill the head from the skid first, else from the new request.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (head_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_data_nxt  = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = push_data;
    end
  end

  // Control flags reset; payload registers do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/touch_gesture_classifier_top.sv
// Top level of the touch gesture classifier: config registers, core and result buffer.
//
//   Channel | Direction | Handshake             | Payload
//   in_     | input     | in_valid / in_stall   | tgc_in_t (touching, pos_x, pos_y, time_ms)
//   out_    | output    | out_valid / out_stall | tgc_out_t (kind, origin_x, origin_y)
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index (3b), cfg_data (16b)
//
// Each sample yields one result, registered once its request is taken; one sample per cycle
// is sustained while in_stall is low, set by the core's single compare-and-update pass.
// Reset (rst_n low, synchronous) clears the touch state and loads the default register set.
// The two-entry result buffer takes requests while one result waits; in_stall rises only
// when both entries are held by a stalled output. Config writes are always ready.
`timescale 1ns / 1ps
module touch_gesture_classifier_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tgc_pkg::tgc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output tgc_pkg::tgc_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);
  import tgc_pkg::*;

  tgc_cfg_t    cfg_r;
  tgc_out_t    core_result;
  tgc_status_t status;
  logic        buf_full;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign in_fire   = in_valid && !buf_full;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_window <= 16'd50;
      cfg_r.long_press_time <= 16'd600;
      cfg_r.long_press_slop <= 13'd20;
      cfg_r.swipe_timeout   <= 16'd500;
      cfg_r.swipe_threshold <= 13'd60;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg_r.debounce_window <= cfg_data;
        REG_LONG_TIME:  cfg_r.long_press_time <= cfg_data;
        REG_LONG_SLOP:  cfg_r.long_press_slop <= cfg_data[12:0];
        REG_SWIPE_TOUT: cfg_r.swipe_timeout   <= cfg_data;
        REG_SWIPE_THR:  cfg_r.swipe_threshold <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Classification core.
  tgc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .sample_fire (in_fire),
    .sample      (in_data),
    .cfg         (cfg_r),
    .result      (core_result),
    .status      (status)
  );

  // Result buffer.
  tgc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_data (core_result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A full buffer always has its head occupied.
  assert property (@(posedge clk) disable iff (!rst_n) buf_full |-> out_valid)
    else $error("skid entry held while output register is empty");

  // A long press leaves the touch down and marked as fired.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && core_result.kind == KIND_LONG) |=> (status.is_down && status.has_fired))
    else $error("long press did not mark the touch as fired");

  // A tap or swipe only comes from a release.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && core_result.kind != KIND_NONE && core_result.kind != KIND_LONG)
      |=> !status.is_down)
    else $error("tap or swipe reported while touch still down");

  // A long press needs an active touch that had not fired yet.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && core_result.kind == KIND_LONG) |-> (status.is_down && !status.has_fired))
    else $error("long press fired without an eligible touch");

endmodule
